// ===== src/jtsc_pkg.sv =====
// Shared types, token and status codes, and defaults for the JSON token structure checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jtsc_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_NODES   = 4096;
	localparam int DEF_STACK_DEPTH = 64;

	// Fixed field widths
	localparam int KIND_W = 4;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 12;
	localparam int LVL_W  = 7;
	localparam int PH_W   = 3;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;

	localparam logic [LVL_W-1:0] MAX_DEPTH_RST = 7'd64;
	localparam logic [IDX_W-1:0] CNT_SAT       = 12'hFFF;

	// Token kinds
	localparam logic [KIND_W-1:0] TK_LBRACE   = 4'd0;
	localparam logic [KIND_W-1:0] TK_RBRACE   = 4'd1;
	localparam logic [KIND_W-1:0] TK_LBRACKET = 4'd2;
	localparam logic [KIND_W-1:0] TK_RBRACKET = 4'd3;
	localparam logic [KIND_W-1:0] TK_STRING   = 4'd4;
	localparam logic [KIND_W-1:0] TK_NUMBER   = 4'd5;
	localparam logic [KIND_W-1:0] TK_NULL     = 4'd6;
	localparam logic [KIND_W-1:0] TK_TRUE     = 4'd7;
	localparam logic [KIND_W-1:0] TK_FALSE    = 4'd8;
	localparam logic [KIND_W-1:0] TK_COLON    = 4'd9;
	localparam logic [KIND_W-1:0] TK_COMMA    = 4'd10;
	localparam logic [KIND_W-1:0] TK_EOF      = 4'd11;
	localparam logic [KIND_W-1:0] TK_LEX_ERR  = 4'd12;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd1;
	localparam logic [STAT_W-1:0] ST_TOO_DEEP  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	// Grammar phase codes
	localparam logic [PH_W-1:0] PH_START        = 3'd0;
	localparam logic [PH_W-1:0] PH_AFTER_OPEN   = 3'd1;
	localparam logic [PH_W-1:0] PH_EXPECT_KEY   = 3'd2;
	localparam logic [PH_W-1:0] PH_EXPECT_COLON = 3'd3;
	localparam logic [PH_W-1:0] PH_EXPECT_VALUE = 3'd4;
	localparam logic [PH_W-1:0] PH_AFTER_VALUE  = 3'd5;
	localparam logic [PH_W-1:0] PH_DONE         = 3'd6;

	// One open container
	typedef struct packed {
		logic             is_obj;
		logic [IDX_W-1:0] child_cnt;
		logic [IDX_W-1:0] parent_idx;
	} scope_entry_t;

	// Stack update requested by the grammar logic
	typedef struct packed {
		logic         push;
		logic         pop;
		logic         inc_top;
		logic         clear;
		scope_entry_t entry;
	} stack_op_t;

	// One result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              node_made;
		logic [IDX_W-1:0]  node_index;
		logic              has_parent;
		logic [IDX_W-1:0]  parent_index;
		logic [IDX_W-1:0]  child_position;
		logic              is_key;
		logic [LVL_W-1:0]  nesting_level;
		logic              complete;
	} result_t;

endpackage

`default_nettype wire

// ===== src/jtsc_scope_stack.sv =====
// Scope stack: depth pointer, top and second entries in flops, deeper entries in a RAM.
// Depends on jtsc_pkg.
`default_nettype none

module jtsc_scope_stack #(
	parameter int STACK_DEPTH = jtsc_pkg::DEF_STACK_DEPTH,
	localparam int DW = $clog2(STACK_DEPTH + 1),
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire jtsc_pkg::stack_op_t op,
	output logic [DW-1:0]          depth,
	output jtsc_pkg::scope_entry_t top
);
	import jtsc_pkg::*;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_d;
	scope_entry_t  top_q;
	scope_entry_t  sec_q;
	scope_entry_t  top_inc;
	scope_entry_t  rd_q;
	scope_entry_t  mem [STACK_DEPTH];

	logic [DW-1:0] d_m2;
	logic [DW-1:0] d_m3;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          wr_en;

	always_comb begin
		depth_d = depth_q;
		if (en) begin
			if (op.clear) begin
				depth_d = '0;
			end else if (op.push) begin
				depth_d = depth_q + DW'(1);
			end else if (op.pop) begin
				depth_d = depth_q - DW'(1);
			end
		end
	end

	always_comb begin
		top_inc = top_q;
		if (op.inc_top && top_q.child_cnt != CNT_SAT) begin
			top_inc.child_cnt = top_q.child_cnt + IDX_W'(1);
		end
	end

	// RAM holds entries below the second; read port tracks entry depth-3
	assign d_m2    = depth_q - DW'(2);
	assign d_m3    = depth_d - DW'(3);
	assign wr_addr = d_m2[AW-1:0];
	assign rd_addr = d_m3[AW-1:0];
	assign wr_en   = en && op.push && (depth_q >= DW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (op.push) begin
				sec_q <= top_inc;
				top_q <= op.entry;
			end else if (op.pop) begin
				top_q <= sec_q;
				sec_q <= rd_q;
			end else if (op.inc_top) begin
				top_q <= top_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sec_q;
		end
		// push moves the read pointer onto the entry being written
		if (wr_en && wr_addr == rd_addr) begin
			rd_q <= sec_q;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign depth = depth_q;
	assign top   = top_q;

endmodule

`default_nettype wire

// ===== src/jtsc_grammar.sv =====
// Per-token grammar check: result fields and next state from the current state and top entry.
// Depends on jtsc_pkg.
`default_nettype none

module jtsc_grammar #(
	parameter int MAX_NODES   = jtsc_pkg::DEF_MAX_NODES,
	parameter int STACK_DEPTH = jtsc_pkg::DEF_STACK_DEPTH,
	localparam int DW = $clog2(STACK_DEPTH + 1),
	localparam int CW = $clog2(MAX_NODES + 1)
) (
	input  wire [jtsc_pkg::KIND_W-1:0] kind,
	input  wire [DW-1:0]               depth,
	input  wire [CW-1:0]               node_cnt,
	input  wire [jtsc_pkg::PH_W-1:0]   phase,
	input  wire [jtsc_pkg::STAT_W-1:0] err,
	input  wire jtsc_pkg::scope_entry_t top,
	input  wire [jtsc_pkg::LVL_W-1:0]  max_depth,
	output jtsc_pkg::result_t          res,
	output jtsc_pkg::stack_op_t        op,
	output logic [jtsc_pkg::PH_W-1:0]  phase_d,
	output logic [jtsc_pkg::STAT_W-1:0] err_d,
	output logic [CW-1:0]              cnt_d
);
	import jtsc_pkg::*;

	localparam int LW = (DW > LVL_W) ? DW : LVL_W;

	logic              in_obj;
	logic              in_arr;
	logic              val_ok;
	logic              key_ok;
	logic              close_ok;
	logic              at_limit;
	logic              full;
	logic [LW-1:0]     depth_l;
	logic [LW-1:0]     md_l;
	logic [LW-1:0]     sd_l;
	logic [LW-1:0]     limit;
	logic [CW+IDX_W-1:0] cnt_ext;
	logic [IDX_W-1:0]  cnt_idx;
	logic [PH_W-1:0]   ph_leaf;
	logic [PH_W-1:0]   ph_close;
	logic [DW-1:0]     depth_after;
	logic [DW+LVL_W-1:0] lvl_ext;
	logic [STAT_W-1:0] e;
	logic              make;
	logic              key;

	assign in_obj   = (depth != '0) && top.is_obj;
	assign in_arr   = (depth != '0) && !top.is_obj;
	assign val_ok   = (phase == PH_START) || (phase == PH_EXPECT_VALUE)
	                  || (phase == PH_AFTER_OPEN && in_arr);
	assign key_ok   = (phase == PH_EXPECT_KEY) || (phase == PH_AFTER_OPEN && in_obj);
	assign close_ok = (depth != '0) && (phase == PH_AFTER_VALUE || phase == PH_AFTER_OPEN);

	assign depth_l  = LW'(depth);
	assign md_l     = LW'(max_depth);
	assign sd_l     = LW'(STACK_DEPTH);
	assign limit    = (md_l < sd_l) ? md_l : sd_l;
	assign at_limit = depth_l >= limit;
	assign full     = node_cnt >= CW'(MAX_NODES);

	assign cnt_ext  = {{IDX_W{1'b0}}, node_cnt};
	assign cnt_idx  = cnt_ext[IDX_W-1:0];

	assign ph_leaf  = (depth != '0) ? PH_AFTER_VALUE : PH_DONE;
	assign ph_close = (depth != DW'(1)) ? PH_AFTER_VALUE : PH_DONE;

	always_comb begin
		res     = '0;
		op      = '0;
		phase_d = phase;
		err_d   = err;
		cnt_d   = node_cnt;
		e       = ST_OK;
		make    = 1'b0;
		key     = 1'b0;
		depth_after = depth;
		lvl_ext = '0;

		if (kind == TK_EOF) begin
			if (err != ST_OK) begin
				res.status = err;
			end else if (phase != PH_DONE) begin
				res.status = ST_MALFORMED;
			end else begin
				res.complete = 1'b1;
			end
			op.clear = 1'b1;
			phase_d  = PH_START;
			err_d    = ST_OK;
			cnt_d    = '0;
		end else if (err != ST_OK) begin
			res.status = err;
			lvl_ext    = {{LVL_W{1'b0}}, depth};
			res.nesting_level = lvl_ext[LVL_W-1:0];
		end else begin
			unique case (kind) inside
				TK_LBRACE, TK_LBRACKET: begin
					if (!val_ok) begin
						e = ST_MALFORMED;
					end else if (at_limit) begin
						e = ST_TOO_DEEP;
					end else if (full) begin
						e = ST_FULL;
					end else begin
						make = 1'b1;
						op.push = 1'b1;
						op.entry.is_obj = (kind == TK_LBRACE);
						op.entry.child_cnt = '0;
						op.entry.parent_idx = cnt_idx;
						phase_d = PH_AFTER_OPEN;
					end
				end
				TK_RBRACE, TK_RBRACKET: begin
					if (!close_ok || in_obj != (kind == TK_RBRACE)) begin
						e = ST_MALFORMED;
					end else begin
						op.pop  = 1'b1;
						phase_d = ph_close;
					end
				end
				TK_STRING: begin
					if (key_ok) begin
						if (full) begin
							e = ST_FULL;
						end else begin
							make    = 1'b1;
							key     = 1'b1;
							phase_d = PH_EXPECT_COLON;
						end
					end else if (!val_ok) begin
						e = ST_MALFORMED;
					end else if (full) begin
						e = ST_FULL;
					end else begin
						make    = 1'b1;
						phase_d = ph_leaf;
					end
				end
				TK_NUMBER, TK_NULL, TK_TRUE, TK_FALSE: begin
					if (!val_ok) begin
						e = ST_MALFORMED;
					end else if (full) begin
						e = ST_FULL;
					end else begin
						make    = 1'b1;
						phase_d = ph_leaf;
					end
				end
				TK_COLON: begin
					if (phase == PH_EXPECT_COLON) begin
						phase_d = PH_EXPECT_VALUE;
					end else begin
						e = ST_MALFORMED;
					end
				end
				TK_COMMA: begin
					if (phase == PH_AFTER_VALUE && depth != '0) begin
						phase_d = in_obj ? PH_EXPECT_KEY : PH_EXPECT_VALUE;
					end else begin
						e = ST_MALFORMED;
					end
				end
				default: begin
					// lexer error and unused kinds
					e = ST_MALFORMED;
				end
			endcase

			if (e != ST_OK) begin
				op         = '0;
				phase_d    = phase;
				err_d      = e;
				res.status = e;
			end else if (make) begin
				res.node_made  = 1'b1;
				res.node_index = cnt_idx;
				res.is_key     = key;
				if (depth != '0) begin
					res.has_parent     = 1'b1;
					res.parent_index   = top.parent_idx;
					res.child_position = top.child_cnt;
					op.inc_top         = 1'b1;
				end
				cnt_d = node_cnt + CW'(1);
			end

			if (op.push) begin
				depth_after = depth + DW'(1);
			end else if (op.pop) begin
				depth_after = depth - DW'(1);
			end
			lvl_ext = {{LVL_W{1'b0}}, depth_after};
			res.nesting_level = lvl_ext[LVL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/json_token_structure_checker_unit.sv =====
// Top level of the JSON token structure checker: stream ports, token and result registers.
// Depends on jtsc_pkg, jtsc_grammar and jtsc_scope_stack.
`default_nettype none

// JSON token structure checker. One lexer token kind comes in per input beat and exactly one
// result beat goes out for it, in order. Each token is checked against the JSON grammar
// (objects of key, colon, value members split by commas, arrays of values, empty containers
// allowed, no trailing comma) using a scope stack of up to STACK_DEPTH open containers.
// Tokens that create a node report its index in document order, its parent, its position
// among the parent's children and whether it is a key. The first error sticks until an eof
// token, which reports the document outcome and resets the checker for the next document.
// Throughput is one token per clock while the result stream drains: the token register feeds
// the grammar logic, which reads only the registered top of the stack, and the result is
// registered in the output register when the token advances. The output register and the
// token register decouple the two sides, so a new token is taken while a result waits
// for m_axis_tready. max_depth may be written only while no token is in flight; the limit
// in use is min(max_depth, STACK_DEPTH).
// No clearing pass is needed after reset.
module json_token_structure_checker_unit #(
	parameter int MAX_NODES   = jtsc_pkg::DEF_MAX_NODES,
	parameter int STACK_DEPTH = jtsc_pkg::DEF_STACK_DEPTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration: max_depth
	input  wire                              cfg_we,
	input  wire [jtsc_pkg::LVL_W-1:0]        cfg_wdata,
	// token stream
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [jtsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [3:0] token_kind, [7:4] zero
	// result stream
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [1:0] status, [2] node_made, [14:3] node_index, [15] has_parent,
	// [27:16] parent_index, [39:28] child_position, [40] is_key,
	// [47:41] nesting_level, [48] complete, [55:49] zero
	output logic [jtsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import jtsc_pkg::*;

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = $clog2(MAX_NODES + 1);

	// token register
	logic              tok_valid_s1;
	logic [KIND_W-1:0] tok_kind_s1;

	// document state
	logic [CW-1:0]     node_cnt_q;
	logic [PH_W-1:0]   phase_q;
	logic [STAT_W-1:0] err_q;
	logic [LVL_W-1:0]  max_depth_q;

	// result register
	logic                   res_valid_q;
	logic [OUT_TDATA_W-1:0] res_data_q;

	// grammar outputs
	result_t           res;
	stack_op_t         op;
	logic [PH_W-1:0]   phase_d;
	logic [STAT_W-1:0] err_d;
	logic [CW-1:0]     cnt_d;

	logic [DW-1:0]     depth;
	scope_entry_t      top;

	logic              advance;

	// token moves into the result register when that register is free or draining
	assign advance       = tok_valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !tok_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			tok_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tok_kind_s1 <= s_axis_tdata[KIND_W-1:0];
		end
	end

	jtsc_grammar #(
		.MAX_NODES   (MAX_NODES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_grammar (
		.kind      (tok_kind_s1),
		.depth     (depth),
		.node_cnt  (node_cnt_q),
		.phase     (phase_q),
		.err       (err_q),
		.top       (top),
		.max_depth (max_depth_q),
		.res       (res),
		.op        (op),
		.phase_d   (phase_d),
		.err_d     (err_d),
		.cnt_d     (cnt_d)
	);

	jtsc_scope_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (op),
		.depth  (depth),
		.top    (top)
	);

	// document state commits only when a token is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q <= '0;
			phase_q    <= PH_START;
			err_q      <= ST_OK;
		end else if (advance) begin
			node_cnt_q <= cnt_d;
			phase_q    <= phase_d;
			err_q      <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= MAX_DEPTH_RST;
		end else if (cfg_we) begin
			max_depth_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_data_q <= {7'd0, res.complete, res.nesting_level, res.is_key,
			               res.child_position, res.parent_index, res.has_parent,
			               res.node_index, res.node_made, res.status};
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_data_q;

endmodule

`default_nettype wire
